// ===== hw/rtl/sct_pkg.sv =====
// Shared constants, register codes and controller/datapath interface types.
`timescale 1ns / 1ps

package sct_pkg;

  localparam int FRAC_BITS_DEF = 20;
  localparam int MAX_TERMS_DEF = 128;

  localparam int CNT_W   = 7;
  localparam int ANGLE_W = 32;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // 2*pi with 60 fraction bits; rounded to the working precision at elaboration
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

  localparam logic [CNT_W-1:0] SINE_CNT_RST   = 7'd10;
  localparam logic [CNT_W-1:0] COSINE_CNT_RST = 7'd109;

  typedef enum logic {
    REG_SINE_CNT   = 1'b0,
    REG_COSINE_CNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic red;
    logic sq;
    logic x2;
    logic mul;
    logic rnd;
    logic rcp;
    logic qd;
    logic fix;
    logic acc;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic in_zero;
    logic red_last;
    logic no_terms;
    logic last_term;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/sct_regs.sv =====
// APB register file holding the sine and cosine term counts.
`timescale 1ns / 1ps

module sct_regs import sct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CNT_W-1:0]  sine_cnt,
  output logic [CNT_W-1:0]  cosine_cnt
);

  reg_idx_t sel;

  assign sel    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sine_cnt   <= SINE_CNT_RST;
      cosine_cnt <= COSINE_CNT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (sel)
        REG_SINE_CNT:   sine_cnt   <= pwdata[CNT_W-1:0];
        REG_COSINE_CNT: cosine_cnt <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_SINE_CNT:   prdata = APB_DW'(sine_cnt);
      REG_COSINE_CNT: prdata = APB_DW'(cosine_cnt);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/sct_ctrl.sv =====
// Sequencer: steps range reduction and the per-term multiply/divide loop.
`timescale 1ns / 1ps

module sct_ctrl import sct_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_RED  = 11'b00000000010,
    ST_SQ   = 11'b00000000100,
    ST_X2   = 11'b00000001000,
    ST_MUL  = 11'b00000010000,
    ST_RND  = 11'b00000100000,
    ST_RCP  = 11'b00001000000,
    ST_QD   = 11'b00010000000,
    ST_FIX  = 11'b00100000000,
    ST_ACC  = 11'b01000000000,
    ST_FIN  = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          // zero angle needs no series
          state_next = sts.in_zero ? ST_FIN : ST_RED;
        end
      end
      ST_RED: begin
        cmd.red = 1'b1;
        if (sts.red_last) begin
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq     = 1'b1;
        state_next = ST_X2;
      end
      ST_X2: begin
        cmd.x2     = 1'b1;
        state_next = sts.no_terms ? ST_ACC : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_RND;
      end
      ST_RND: begin
        cmd.rnd    = 1'b1;
        state_next = ST_RCP;
      end
      ST_RCP: begin
        cmd.rcp    = 1'b1;
        state_next = ST_QD;
      end
      ST_QD: begin
        cmd.qd     = 1'b1;
        state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = sts.last_term ? ST_ACC : ST_MUL;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the beat
        if (sts.out_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sct_dp.sv =====
// Datapath: range reduction, shared multiplier, reciprocal divide and series sum.
`timescale 1ns / 1ps

module sct_dp import sct_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       op,
  input  logic signed [ANGLE_W-1:0]  angle,
  input  logic [CNT_W-1:0]           sine_cnt,
  input  logic [CNT_W-1:0]           cosine_cnt,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [FRAC_BITS+2:0] value
);

  localparam int NW   = FRAC_BITS + 12;   // divide operand / multiplier port width
  localparam int PW   = 2 * NW;
  localparam int XW   = FRAC_BITS + 3;    // reduced angle magnitude
  localparam int X2W  = FRAC_BITS + 6;    // x squared
  localparam int TW   = FRAC_BITS + 8;    // term magnitude
  localparam int SW   = FRAC_BITS + 12;   // running sum, signed
  localparam int OW   = FRAC_BITS + 3;
  localparam int NMAX = (MAX_TERMS - 1 < 127) ? MAX_TERMS - 1 : 127;
  localparam int IW   = $clog2(NMAX + 1);
  localparam int KMAX = 2 * NMAX;
  localparam int KW   = $clog2(KMAX + 1);
  localparam int DW   = $clog2(KMAX * (KMAX + 1) + 1);
  localparam int SR   = 29 - FRAC_BITS;   // restoring steps of the 2*pi remainder

  localparam logic [63:0] P64 =
    (TWO_PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam logic [ANGLE_W-1:0] P32  = P64[ANGLE_W-1:0];
  localparam logic [ANGLE_W-1:0] PSH0 = P32 << (SR - 1);
  localparam logic [PW-1:0]      HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic [TW-1:0]      ONE_T = TW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] LIM   = SW'(1) << (FRAC_BITS + 1);
  localparam logic signed [SW-1:0] NLIM  = -LIM;

  // divisor k*(k+1) and floor(2^NW / (k*(k+1))), indexed by k
  logic [DW-1:0] dtab [KMAX+1];
  logic [NW-1:0] rtab [KMAX+1];

  for (genvar g = 0; g <= KMAX; g++) begin : g_tab
    localparam longint unsigned DV = (g == 0) ? 1 : g * (g + 1);
    localparam longint unsigned RV = (64'd1 << NW) / DV;
    assign dtab[g] = DW'(DV);
    assign rtab[g] = NW'(RV);
  end

  logic                    fn_cos;
  logic                    aneg;
  logic [IW-1:0]           n;
  logic [IW-1:0]           i;
  logic [ANGLE_W-1:0]      r;
  logic [ANGLE_W-1:0]      psh;
  logic [PW-1:0]           prod;
  logic [X2W-1:0]          x2;
  logic [NW-1:0]           nreg;
  logic [NW-1:0]           qreg;
  logic [TW-1:0]           term_mag;
  logic                    term_neg;
  logic signed [SW-1:0]    sum;

  logic [ANGLE_W-1:0]      angle_mag;
  logic [CNT_W-1:0]        cnt_sel;
  logic [IW-1:0]           n_load;
  logic [KW-1:0]           k;
  logic [DW-1:0]           d;
  logic [NW-1:0]           rcp;
  logic [XW-1:0]           xsel;
  logic [PW-1:0]           rnd_full;
  logic [NW-1:0]           rem;
  logic [NW-1:0]           q_fix;
  logic [NW-1:0]           mul_a;
  logic [NW-1:0]           mul_b;
  logic [PW-1:0]           mul_p;
  logic signed [SW-1:0]    term_ext;
  logic signed [SW-1:0]    term_add;
  logic signed [SW-1:0]    sat;

  assign angle_mag = angle[ANGLE_W-1] ? (~$unsigned(angle)) + ANGLE_W'(1) : $unsigned(angle);
  assign cnt_sel   = op ? cosine_cnt : sine_cnt;
  assign n_load    = (cnt_sel > CNT_W'(NMAX)) ? IW'(NMAX) : IW'(cnt_sel);

  // k = 2(i+1) for sine, 2i+1 for cosine, i counting from zero
  assign k    = {i, 1'b0} + (fn_cos ? KW'(1) : KW'(2));
  assign d    = dtab[k];
  assign rcp  = rtab[k];

  // a remainder of zero stands for a full turn
  assign xsel     = (r == '0) ? P32[XW-1:0] : r[XW-1:0];
  assign rnd_full = prod + HALF;
  assign rem      = nreg - prod[NW-1:0];
  assign q_fix    = qreg + NW'(rem >= NW'(d));

  assign term_ext = $signed({{(SW-TW){1'b0}}, term_mag});
  assign term_add = term_neg ? -term_ext : term_ext;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.sq) begin
      mul_a = NW'(xsel);
      mul_b = NW'(xsel);
    end else if (cmd.mul) begin
      mul_a = NW'(term_mag);
      mul_b = NW'(x2);
    end else if (cmd.rcp) begin
      mul_a = nreg;
      mul_b = rcp;
    end else if (cmd.qd) begin
      mul_a = prod[PW-1:NW];
      mul_b = NW'(d);
    end
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.sq || cmd.mul || cmd.rcp || cmd.qd) begin
      prod <= mul_p;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fn_cos <= op;
      aneg   <= angle[ANGLE_W-1];
      n      <= n_load;
      i      <= '0;
      r      <= angle_mag;
      psh    <= PSH0;
      sum    <= op ? ONE_S : '0;
    end
    if (cmd.red) begin
      if (r >= psh) begin
        r <= r - psh;
      end
      psh <= psh >> 1;
    end
    if (cmd.sq) begin
      term_mag <= fn_cos ? ONE_T : TW'(xsel);
      term_neg <= fn_cos ? 1'b0 : aneg;
      sum      <= '0;
    end
    if (cmd.x2) begin
      x2 <= rnd_full[FRAC_BITS +: X2W];
    end
    if (cmd.mul || cmd.acc) begin
      sum <= sum + term_add;
    end
    if (cmd.rnd) begin
      // bias by half the divisor so the quotient rounds to nearest
      nreg <= rnd_full[FRAC_BITS +: NW] + NW'(d >> 1);
    end
    if (cmd.qd) begin
      qreg <= prod[PW-1:NW];
    end
    if (cmd.fix) begin
      term_mag <= q_fix[TW-1:0];
      term_neg <= ~term_neg;
      i        <= i + IW'(1);
    end
  end

  always_comb begin
    if (sum > LIM) begin
      sat = LIM;
    end else if (sum < NLIM) begin
      sat = NLIM;
    end else begin
      sat = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      value <= sat[OW-1:0];
    end
  end

  assign sts.in_zero   = (angle == '0);
  assign sts.red_last  = (psh == P32);
  assign sts.no_terms  = (n == '0);
  assign sts.last_term = ((i + IW'(1)) == n);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// ===== hw/rtl/sine_cosine_taylor.sv =====
// Fixed-point sine/cosine by truncated Taylor series. Each beat carries an angle in
// radians (signed, FRAC_BITS fraction bits) and op (0 sine, 1 cosine); one saturated
// result comes back per beat. Angles beyond +-2*pi are first folded by a restoring
// remainder against 2*pi, one compare-subtract per cycle (29-FRAC_BITS steps). The
// series then runs on a single shared multiplier, in five steps per term (product,
// round, reciprocal multiply, back-multiply, correct), for as many terms as the term
// count of the chosen function; a zero angle skips both reduction and series.
// One item is in flight at a time; the next is taken while a result waits in the
// output register. Term counts live at APB offsets 0x0 (sine) and 0x4 (cosine).
`timescale 1ns / 1ps

module sine_cosine_taylor import sct_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [APB_AW-1:0]           paddr,
  input  logic [APB_DW-1:0]           pwdata,
  output logic [APB_DW-1:0]           prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic signed [ANGLE_W-1:0]   angle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FRAC_BITS+2:0] value
);

  logic [CNT_W-1:0] sine_cnt;
  logic [CNT_W-1:0] cosine_cnt;
  cmd_t             cmd;
  sts_t             sts;

  sct_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .sine_cnt   (sine_cnt),
    .cosine_cnt (cosine_cnt)
  );

  sct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sct_dp #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .angle      (angle),
    .sine_cnt   (sine_cnt),
    .cosine_cnt (cosine_cnt),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value)
  );

endmodule

// ===== verif/tb_sine_cosine_taylor.sv =====
// Self-checking testbench for the fixed-point sine/cosine Taylor series block.
`timescale 1ns / 1ps

module tb_sine_cosine_taylor;
  import sct_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int VAL_W = FB + 3;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int DRAIN_CYCLES = 700;
  localparam int HOLD_CYCLES = 500;
  localparam logic [63:0] MAG_MAX = (64'd1 << 56) - 64'd1;
  localparam logic signed [63:0] TWO_PI_FX = (TWO_PI_Q60 + (64'd1 << (59 - FB))) >> (60 - FB);
  localparam int TWO_PI_I = int'(TWO_PI_FX);

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_PATTERN, READY_COIN} ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic signed [ANGLE_W-1:0] angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VAL_W-1:0] value;

  logic [CNT_W-1:0] sine_terms = SINE_CNT_RST;
  logic [CNT_W-1:0] cosine_terms = COSINE_CNT_RST;
  logic [VAL_W-1:0] expected_q[$];
  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit gaps_on = 1'b0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  sine_cosine_taylor dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .angle(angle),
    .out_valid(out_valid), .out_ready(out_ready), .value(value)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sine_cosine_taylor regression: fail");
      $finish;
    end
  end

  // magnitude product back to FB fraction bits, rounded half up, saturated
  function automatic logic [63:0] round_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] s;
    s = {64'd0, a} * {64'd0, b};
    s = (s + (128'd1 << (FB - 1))) >> FB;
    return (s > {64'd0, MAG_MAX}) ? MAG_MAX : s[63:0];
  endfunction

  function automatic logic [VAL_W-1:0] sincos_expect(logic is_cos, logic signed [31:0] a);
    logic signed [63:0] x, x2, term, acc, lim;
    logic [63:0] mag, d;
    int n, k;
    logic neg;
    lim = 64'sd2 <<< FB;
    if (a == 0) begin
      acc = is_cos ? (64'sd1 <<< FB) : 64'sd0;
    end else begin
      x = a;
      if (x > TWO_PI_FX) begin
        x = x % TWO_PI_FX;
        if (x == 0) x = TWO_PI_FX;
      end else if (x < -TWO_PI_FX) begin
        x = -((-x) % TWO_PI_FX);
        if (x == 0) x = -TWO_PI_FX;
      end
      mag = (x < 0) ? -x : x;
      x2 = round_mul(mag, mag);
      n = is_cos ? cosine_terms : sine_terms;
      term = is_cos ? (64'sd1 <<< FB) : x;
      acc = term;
      for (int i = 1; i <= n; i++) begin
        k = is_cos ? 2 * i - 1 : 2 * i;
        d = k * (k + 1);
        // the new term flips sign; a zero term stays zero
        neg = (term >= 0);
        mag = round_mul((term < 0) ? -term : term, x2);
        mag = (mag + d / 2) / d;
        if (mag > MAG_MAX) mag = MAG_MAX;
        term = neg ? -$signed(mag) : $signed(mag);
        acc = acc + term;
      end
    end
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    return acc[VAL_W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic ready_pick();
    case (ready_mode)
      READY_ALWAYS:  return 1'b1;
      READY_MOSTLY:  return $urandom_range(0, 3) != 0;
      READY_PATTERN: return (cycle_count % 9) < 5;
      default:       return $urandom_range(0, 1) == 1;
    endcase
  endfunction

  // receiver: hold off for a long stretch on request, else follow the stall pattern
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ready_pick();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing expected", 32'(value), 32'd0);
      end else begin
        logic [VAL_W-1:0] want;
        want = expected_q.pop_front();
        if (value !== want) report_mismatch("value", 32'(value), 32'(want));
      end
    end
  end

  task automatic send_angle(logic is_cos, logic signed [31:0] a);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    op <= is_cos;
    angle <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(sincos_expect(is_cos, a));
    burst_left--;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check(reg_idx_t idx, logic [CNT_W-1:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CNT_W-1:0] !== want) report_mismatch("register read", prdata, 32'(want));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_terms(logic [CNT_W-1:0] s, logic [CNT_W-1:0] c);
    wait_idle();
    apb_write(REG_SINE_CNT, 32'(s) | ($urandom << CNT_W));
    apb_write(REG_COSINE_CNT, 32'(c) | ($urandom << CNT_W));
    sine_terms = s;
    cosine_terms = c;
    apb_check(REG_SINE_CNT, s);
    apb_check(REG_COSINE_CNT, c);
  endtask

  function automatic logic signed [31:0] pick_angle();
    int t;
    case ($urandom_range(0, 5))
      0: t = $urandom;
      1, 2: t = int'($urandom_range(0, 2 * TWO_PI_I)) - TWO_PI_I;
      3: t = $urandom_range(1, 320) * TWO_PI_I + int'($urandom_range(0, 6)) - 3;
      4: t = $urandom_range(0, 2047);
      default: t = $urandom >> $urandom_range(0, 31);
    endcase
    // fold onto either sign
    if ($urandom_range(0, 1) == 1) t = -t;
    return t;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        gaps_on = $urandom_range(0, 2) != 0;
      end
      send_angle($urandom_range(0, 1), pick_angle());
    end
  endtask

  task automatic test_register_reset();
    apb_check(REG_SINE_CNT, SINE_CNT_RST);
    apb_check(REG_COSINE_CNT, COSINE_CNT_RST);
  endtask

  task automatic test_directed_angles();
    logic signed [31:0] corners[11];
    corners = '{0, 1, -1, 32'sh7FFF_FFFF, 32'sh8000_0000, TWO_PI_I, -TWO_PI_I,
                TWO_PI_I + 1, -TWO_PI_I - 1, 2 * TWO_PI_I, -2 * TWO_PI_I};
    ready_mode = READY_ALWAYS;
    gaps_on = 1'b0;
    foreach (corners[i]) begin
      send_angle(1'b0, corners[i]);
      send_angle(1'b1, corners[i]);
    end
  endtask

  task automatic test_reset_counts_random();
    run_random(400);
  endtask

  task automatic test_no_extra_terms();
    set_terms(7'd0, 7'd0);
    // the bare first term of sine saturates beyond two radians
    send_angle(1'b0, TWO_PI_I);
    send_angle(1'b0, -TWO_PI_I);
    send_angle(1'b0, 32'sd3 <<< (FB - 1));
    send_angle(1'b1, TWO_PI_I / 2);
    run_random(150);
  endtask

  task automatic test_max_terms();
    set_terms(7'd127, 7'd127);
    run_random(100);
  endtask

  task automatic test_output_hold_off();
    set_terms(SINE_CNT_RST, COSINE_CNT_RST);
    ready_mode = READY_ALWAYS;
    gaps_on = 1'b0;
    hold_req = hold_req + 1;
    for (int i = 0; i < 16; i++) send_angle(1'b0, pick_angle());
  endtask

  task automatic test_random_counts();
    for (int p = 0; p < 4; p++) begin
      set_terms($urandom_range(0, 127), $urandom_range(0, 127));
      run_random(250);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_directed_angles();
    test_reset_counts_random();
    test_no_extra_terms();
    test_max_terms();
    test_output_hold_off();
    test_random_counts();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) report_mismatch("results never arrived", expected_q.size(), 0);
    if (errors == 0) begin
      $display("sine_cosine_taylor regression: pass");
    end else begin
      $display("sine_cosine_taylor regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sct_pkg.sv
hw/rtl/sct_regs.sv
hw/rtl/sct_ctrl.sv
hw/rtl/sct_dp.sv
hw/rtl/sine_cosine_taylor.sv
verif/tb_sine_cosine_taylor.sv
